FILE: sv/u8ncm_pkg.sv
// Shared types, constants and national character table for the UTF-8 mapper.
// No dependencies; used by every module of the block.
package u8ncm_pkg;

    // Table of national code points, index order gives the display code offset
    localparam int TABLE_SIZE        = 19;
    localparam int TABLE_ENTRIES_DEF = 19;

    localparam logic [10:0] NATIONAL_CP [TABLE_SIZE] = '{
        11'h104, 11'h105, 11'h106, 11'h107, 11'h118, 11'h119, 11'h141, 11'h142,
        11'h143, 11'h144, 11'h0d3, 11'h0f3, 11'h15a, 11'h15b, 11'h179, 11'h17a,
        11'h17b, 11'h17c, 11'h0b0
    };

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_MAX_LENGTH   = 2'd0;
    localparam logic [1:0] REG_CODE_BASE    = 2'd1;
    localparam logic [1:0] REG_INVALID_CODE = 2'd2;

    localparam logic [7:0] MAX_LENGTH_RST   = 8'd255;
    localparam logic [7:0] CODE_BASE_RST    = 8'd128;
    localparam logic [7:0] INVALID_CODE_RST = 8'd127;

    // Byte classes
    localparam logic [7:0] LEAD_MIN = 8'h80;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       first_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_position;
        logic [7:0] char_code;
        logic       has_char;
        logic       is_last;
    } t_out_item;

endpackage

FILE: sv/u8ncm_lookup.sv
// National character lookup: parallel compare of an 11-bit code point
// against the package table. Depends on u8ncm_pkg.
module u8ncm_lookup #(
    parameter int TABLE_ENTRIES = u8ncm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic [10:0] i_code_point,
    input  logic [7:0]  i_code_base,
    input  logic [7:0]  i_invalid_code,
    output logic [7:0]  o_char_code
);
    import u8ncm_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic             hit;
    logic [IDX_W-1:0] hit_idx;

    // Entries are unique, so at most one compare fires
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (i_code_point == NATIONAL_CP[i]) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    // Hit maps to base plus index, wrapping at 8 bits
    assign o_char_code = hit ? (i_code_base + 8'(hit_idx)) : i_invalid_code;

endmodule

FILE: sv/utf8_national_char_mapper.sv
// Top level of the UTF-8 national character mapper.
// Depends on u8ncm_pkg and u8ncm_lookup.
//
// Takes one text byte per cycle while the output is not stalled and gives
// at most one result per byte: an input register feeds a single pass of
// decode and table compare into an output register, so the sustained rate
// is one item per clock. The only loop is the string state (position,
// pending lead byte, finished flag), updated in the same cycle as the
// decode. A lead byte gives no result; the byte after it completes the
// character. The output register acts as a holding stage: the block keeps
// taking items while a result waits, and stalls the input only when a
// result is held and the next byte is already queued. Configuration is
// read back over APB and must only be written while the block holds no item.
module utf8_national_char_mapper #(
    parameter int TABLE_ENTRIES = u8ncm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  u8ncm_pkg::t_in_item          i_in_item,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output u8ncm_pkg::t_out_item         o_out_item,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [u8ncm_pkg::ADDR_W-1:0] paddr,
    input  logic [u8ncm_pkg::DATA_W-1:0] pwdata,
    output logic [u8ncm_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);
    import u8ncm_pkg::*;

    // Configuration registers
    logic [7:0] r_max_length, r_code_base, r_invalid_code;
    logic [1:0] reg_idx;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length   <= MAX_LENGTH_RST;
            r_code_base    <= CODE_BASE_RST;
            r_invalid_code <= INVALID_CODE_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MAX_LENGTH:   r_max_length   <= pwdata[7:0];
                REG_CODE_BASE:    r_code_base    <= pwdata[7:0];
                REG_INVALID_CODE: r_invalid_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MAX_LENGTH:   prdata = {24'd0, r_max_length};
            REG_CODE_BASE:    prdata = {24'd0, r_code_base};
            REG_INVALID_CODE: prdata = {24'd0, r_invalid_code};
            default:          prdata = '0;
        endcase
    end

    // Handshake: the input register moves on when the output slot is free
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance, in_take;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // String state
    logic [7:0] r_pos, n_pos;
    logic       r_pend, n_pend;
    logic [4:0] r_lead, n_lead;
    logic       r_fin, n_fin;

    // Effective state once a first-byte flag has cleared it
    logic [7:0]  eff_pos, pos_inc;
    logic        eff_pend, eff_fin;
    logic [4:0]  eff_lead;
    logic [7:0]  b;
    logic [7:0]  map_code;
    logic        emit;
    t_out_item   res;

    assign b        = r_in_item.text_byte;
    assign eff_pos  = r_in_item.first_byte ? 8'd0 : r_pos;
    assign eff_pend = r_in_item.first_byte ? 1'b0 : r_pend;
    assign eff_lead = r_in_item.first_byte ? 5'd0 : r_lead;
    assign eff_fin  = r_in_item.first_byte ? 1'b0 : r_fin;
    assign pos_inc  = eff_pos + 8'd1;

    u8ncm_lookup #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_lookup (
        .i_code_point   ({eff_lead, b[5:0]}),
        .i_code_base    (r_code_base),
        .i_invalid_code (r_invalid_code),
        .o_char_code    (map_code)
    );

    // Decode of one byte
    always_comb begin
        n_pos  = eff_pos;
        n_pend = eff_pend;
        n_lead = eff_lead;
        n_fin  = eff_fin;
        emit   = 1'b0;
        res    = '{char_position: eff_pos, char_code: 8'd0, has_char: 1'b0, is_last: 1'b1};
        if (eff_fin) begin
            emit = 1'b0;
        end else if (eff_pos >= r_max_length) begin
            // limit already reached: drop the byte, end-only result
            n_fin  = 1'b1;
            n_pend = 1'b0;
            emit   = 1'b1;
        end else if (eff_pend || (b != 8'd0 && b < LEAD_MIN)) begin
            // completed two-byte sequence or plain character
            n_pend        = 1'b0;
            emit          = 1'b1;
            res.char_code = eff_pend ? map_code : b;
            res.has_char  = 1'b1;
            res.is_last   = pos_inc >= r_max_length;
            n_pos         = pos_inc;
            n_fin         = pos_inc >= r_max_length;
        end else if (b == 8'd0) begin
            // terminator
            n_fin = 1'b1;
            emit  = 1'b1;
        end else begin
            // lead byte, held for the next one
            n_lead = b[4:0];
            n_pend = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= 8'd0;
            r_pend      <= 1'b0;
            r_lead      <= 5'd0;
            r_fin       <= 1'b1;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= emit;
                r_pos       <= n_pos;
                r_pend      <= n_pend;
                r_lead      <= n_lead;
                r_fin       <= n_fin;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= res;
        end
    end

endmodule

FILE: sv/u8ncm_checker.sv
// Port-level checks for the UTF-8 national character mapper, with the bind
// that attaches them to the top level. Depends on u8ncm_pkg.
module u8ncm_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input u8ncm_pkg::t_out_item         o_out_item
);
    // No result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // Input back-pressure only while a result is held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with free output");

    // An end-only result carries no code and always closes the string
    a_end_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.has_char |->
            o_out_item.is_last && o_out_item.char_code == 8'd0)
        else $error("malformed end-only result");

endmodule

bind utf8_national_char_mapper u8ncm_checker u_chk (.*);

FILE: sim/utf8_national_char_mapper_tb.sv
// Self-checking testbench for utf8_national_char_mapper: byte stimulus, result checker.
// Needs u8ncm_pkg (item types, register indexes) and the mapper RTL, nothing else.
// Expected results come from a local model of the string decoder, checked in order.
`timescale 1ns / 100ps

module utf8_national_char_mapper_tb;
    import u8ncm_pkg::*;

    localparam int          NATIONAL_COUNT = 19;
    localparam int unsigned QUIET_LIMIT    = 2000;
    localparam int unsigned HOLD_CYCLES    = 200;
    localparam int unsigned SETTLE_CYCLES  = 4;

    // National code points in display code order
    localparam logic [10:0] NATIONAL_TABLE [NATIONAL_COUNT] = '{
        11'h104, 11'h105, 11'h106, 11'h107, 11'h118, 11'h119, 11'h141, 11'h142,
        11'h143, 11'h144, 11'h0d3, 11'h0f3, 11'h15a, 11'h15b, 11'h179, 11'h17a,
        11'h17b, 11'h17c, 11'h0b0
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_item   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_item;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [ADDR_W-1:0]  paddr       = '0;
    logic [DATA_W-1:0]  pwdata      = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // Decoder model: configuration and string state
    logic [7:0]  cfg_max_length   = 8'd255;
    logic [7:0]  cfg_code_base    = 8'd128;
    logic [7:0]  cfg_invalid_code = 8'd127;
    logic [7:0]  pos_count        = 8'd0;
    bit          lead_waiting     = 1'b0;
    logic [4:0]  lead_low         = 5'd0;
    bit          string_done      = 1'b1;

    t_out_item   codes_due [$];
    t_in_item    pending_bytes [$];
    int unsigned queued_total   = 0;
    int unsigned taken_total    = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    logic        in_taken  = 1'b0;
    logic        out_taken = 1'b0;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    bit          rush       = 1'b0;
    bit          hold_req   = 1'b0;
    bit          hold_done  = 1'b0;

    // per side: 0 sender, 1 receiver
    int unsigned calm_left [2];
    bit          calm_run  [2];

    utf8_national_char_mapper DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Idle length for one item; runs of zero-wait items come in stretches
    function automatic int unsigned pick_wait(input int side);
        if (calm_left[side] == 0) begin
            calm_left[side] = $urandom_range(10, 80);
            calm_run[side]  = ($urandom_range(0, 2) == 0);
        end
        calm_left[side] = calm_left[side] - 1;
        return calm_run[side] ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic logic [7:0] national_code(input logic [10:0] cp);
        for (int i = 0; i < NATIONAL_COUNT; i++) begin
            if (NATIONAL_TABLE[i] == cp) return cfg_code_base + 8'(i);
        end
        return cfg_invalid_code;
    endfunction

    // Advance the string state by one byte and queue the result it gives, if any
    function automatic void map_byte(input t_in_item it);
        t_out_item res;
        logic [7:0] code;
        if (it.first_byte) begin
            pos_count    = 8'd0;
            lead_waiting = 1'b0;
            lead_low     = 5'd0;
            string_done  = 1'b0;
        end
        if (string_done) return;
        // limit already reached: byte dropped, end-only result
        if (pos_count >= cfg_max_length) begin
            string_done  = 1'b1;
            lead_waiting = 1'b0;
            codes_due.push_back('{pos_count, 8'h00, 1'b0, 1'b1});
            return;
        end
        if (lead_waiting) begin
            lead_waiting = 1'b0;
            code = national_code({lead_low, it.text_byte[5:0]});
        end else if (it.text_byte == 8'h00) begin
            string_done = 1'b1;
            codes_due.push_back('{pos_count, 8'h00, 1'b0, 1'b1});
            return;
        end else if (!it.text_byte[7]) begin
            code = it.text_byte;
        end else begin
            lead_low     = it.text_byte[4:0];
            lead_waiting = 1'b1;
            return;
        end
        res.char_position = pos_count;
        res.char_code     = code;
        res.has_char      = 1'b1;
        res.is_last       = 8'(pos_count + 8'd1) >= cfg_max_length;
        codes_due.push_back(res);
        pos_count = pos_count + 8'd1;
        if (res.is_last) string_done = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 50) begin
            $display("%0t: %s is 0x%0h, expected 0x%0h", $time, what, got, want);
        end
    endtask

    task automatic queue_byte(input bit first, input logic [7:0] value);
        t_in_item it;
        it.text_byte  = value;
        it.first_byte = first;
        pending_bytes.push_back(it);
        queued_total++;
    endtask

    // Register write: setup cycle, then access cycle until pready
    task automatic apb_write(input logic [1:0] reg_index, input logic [7:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'({reg_index, 2'b00});
        pwdata  = DATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (reg_index)
            REG_MAX_LENGTH:   cfg_max_length   = value;
            REG_CODE_BASE:    cfg_code_base    = value;
            REG_INVALID_CODE: cfg_invalid_code = value;
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] len_cap, input logic [7:0] base,
                              input logic [7:0] bad_code);
        apb_write(REG_MAX_LENGTH, len_cap);
        apb_write(REG_CODE_BASE, base);
        apb_write(REG_INVALID_CODE, bad_code);
    endtask

    // Wait until every byte is taken and every result seen, then let the pipe drain
    task automatic wait_idle();
        while (taken_total != queued_total || codes_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Mostly well-formed strings with random content, some noise and dangling leads
    task automatic queue_random_strings(input int unsigned budget);
        int unsigned stop_at;
        int unsigned len;
        int unsigned pick;
        int unsigned kind;
        logic [10:0] cp;
        stop_at = queued_total + budget;
        while (queued_total < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                len = $urandom_range(0, 30);
                for (int c = 0; c < len; c++) begin
                    kind = $urandom_range(0, 9);
                    if (kind < 5) begin
                        queue_byte(c == 0, 8'($urandom_range(1, 127)));
                    end else if (kind < 8) begin
                        // table hit, with the ignored high bits of both bytes random
                        cp = NATIONAL_TABLE[$urandom_range(0, NATIONAL_COUNT - 1)];
                        queue_byte(c == 0, {1'b1, 2'($urandom), cp[10:6]});
                        queue_byte(1'b0, {2'($urandom), cp[5:0]});
                    end else begin
                        queue_byte(c == 0, {1'b1, 7'($urandom)});
                        queue_byte(1'b0, 8'($urandom));
                    end
                end
                if (len == 0 || $urandom_range(0, 2) != 0) queue_byte(len == 0, 8'h00);
            end else if (pick < 9) begin
                repeat ($urandom_range(1, 6)) queue_byte($urandom_range(0, 3) == 0, 8'($urandom));
            end else begin
                queue_byte(1'($urandom_range(0, 1)), {1'b1, 7'($urandom)});
            end
        end
    endtask

    // Input driver: holds a stalled item, otherwise waits its gap and sends the next
    always @(negedge i_clk) begin : byte_driver
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (gap_left != 0) begin
                i_in_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if (pending_bytes.size() != 0) begin
                i_in_item  <= pending_bytes.pop_front();
                i_in_valid <= 1'b1;
                gap_left   <= rush ? 0 : pick_wait(0);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stall after each item, one long hold-off on request
    always @(negedge i_clk) begin : result_sink
        int unsigned n;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_req && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_done   <= 1'b1;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (out_taken) begin
            n = pick_wait(1);
            i_out_stall <= (n != 0);
            stall_left  <= (n != 0) ? n - 1 : 0;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: check each result against the oldest expectation, model each byte taken
    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        if (!i_rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (codes_due.size() == 0) begin
                    report_mismatch("result with nothing due, char_code",
                                    o_out_item.char_code, 0);
                end else begin
                    want = codes_due.pop_front();
                    if (o_out_item.char_position !== want.char_position)
                        report_mismatch("char_position", o_out_item.char_position,
                                        want.char_position);
                    if (o_out_item.char_code !== want.char_code)
                        report_mismatch("char_code", o_out_item.char_code, want.char_code);
                    if (o_out_item.has_char !== want.has_char)
                        report_mismatch("has_char", o_out_item.has_char, want.has_char);
                    if (o_out_item.is_last !== want.is_last)
                        report_mismatch("is_last", o_out_item.is_last, want.is_last);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                map_byte(i_in_item);
                taken_total++;
            end
            in_taken  <= i_in_valid && !o_in_stall;
            out_taken <= o_out_valid && !i_out_stall;
        end
    end

    // Watchdog: too long with no item moving on either side
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : test_sequence
        logic [7:0] len_cap;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // Reset settings: ASCII extremes, table hits, misses, terminator, restarts
        queue_byte(1'b1, 8'h41);
        queue_byte(1'b0, 8'h7f);
        queue_byte(1'b0, 8'h01);
        queue_byte(1'b0, 8'hc4); queue_byte(1'b0, 8'h84);   // first table entry
        queue_byte(1'b0, 8'hc2); queue_byte(1'b0, 8'hb0);   // last table entry
        queue_byte(1'b0, 8'hc5); queue_byte(1'b0, 8'hbc);
        queue_byte(1'b0, 8'hff); queue_byte(1'b0, 8'h00);   // zero completes a lead
        queue_byte(1'b0, 8'h80); queue_byte(1'b0, 8'h41);   // ASCII completes a lead
        queue_byte(1'b0, 8'hc5); queue_byte(1'b0, 8'hc1);   // lead completes a lead
        queue_byte(1'b0, 8'h00);                             // terminator
        queue_byte(1'b0, 8'h42);                             // finished, no result
        queue_byte(1'b1, 8'hc4);                             // lead left pending...
        queue_byte(1'b1, 8'h42);                             // ...dropped by a new string
        queue_byte(1'b1, 8'h00);                             // empty string
        wait_idle();

        // One-character strings, wrapped code, all-ones codes
        set_config(8'd1, 8'd255, 8'd255);
        queue_byte(1'b1, 8'h41);
        queue_byte(1'b0, 8'h42);
        queue_byte(1'b1, 8'hc3); queue_byte(1'b0, 8'h93);
        queue_byte(1'b1, 8'hc1); queue_byte(1'b0, 8'h01);
        wait_idle();

        // Zero length: every string ends at once, lead bytes dropped
        set_config(8'd0, 8'd0, 8'd0);
        queue_byte(1'b1, 8'h41);
        queue_byte(1'b0, 8'h42);
        queue_byte(1'b1, 8'hc2); queue_byte(1'b0, 8'h80);
        wait_idle();

        // Length lowered below the position mid-string
        set_config(8'd3, 8'd250, 8'd0);
        queue_byte(1'b1, 8'hc2); queue_byte(1'b0, 8'hb0);
        queue_byte(1'b0, 8'h41);
        wait_idle();
        apb_write(REG_MAX_LENGTH, 8'd1);
        queue_byte(1'b0, 8'h7a);
        wait_idle();

        // Same, with a lead byte pending across the change
        apb_write(REG_MAX_LENGTH, 8'd5);
        queue_byte(1'b1, 8'h61);
        queue_byte(1'b0, 8'hc4);
        wait_idle();
        apb_write(REG_MAX_LENGTH, 8'd1);
        queue_byte(1'b0, 8'h84);
        wait_idle();

        // Longest string: cut at 255 characters, the byte after it gives nothing
        set_config(8'd255, 8'd128, 8'd127);
        for (int i = 0; i < 256; i++) queue_byte(i == 0, 8'($urandom_range(1, 127)));
        wait_idle();

        // Random phases, one of them under receiver hold-off with no sender gaps
        for (int p = 0; p < 6; p++) begin
            wait_idle();
            rush = 1'b0;
            case ($urandom_range(0, 7))
                0:       len_cap = 8'd0;
                1:       len_cap = 8'd1;
                2, 3:    len_cap = 8'd255;
                default: len_cap = 8'($urandom_range(2, 40));
            endcase
            if (p == 2) len_cap = 8'd255;
            set_config(len_cap, 8'($urandom), 8'($urandom));
            if (p == 2) begin
                rush     = 1'b1;
                hold_req = 1'b1;
            end
            queue_random_strings(250);
        end
        wait_idle();

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
